[hdl/aid_pkg.sv]
// shared types and constants of the instruction decoder
`default_nettype none
package aid_pkg;

  localparam int unsigned InstrW = 32;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned OpW    = 6;
  localparam int unsigned RegW   = 4;
  localparam int unsigned ImmW   = 32;
  localparam int unsigned StyW   = 3;
  localparam int unsigned SamtW  = 5;
  localparam int unsigned MfW    = 14;
  localparam int unsigned FfW    = 6;
  localparam int unsigned CcW    = 2;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 88;

  // operation codes
  localparam logic [OpW-1:0] OP_B      = 6'd16;
  localparam logic [OpW-1:0] OP_BL     = 6'd17;
  localparam logic [OpW-1:0] OP_BX     = 6'd18;
  localparam logic [OpW-1:0] OP_BLXI   = 6'd19;
  localparam logic [OpW-1:0] OP_BLXR   = 6'd20;
  localparam logic [OpW-1:0] OP_LDR    = 6'd21;
  localparam logic [OpW-1:0] OP_LDRB   = 6'd22;
  localparam logic [OpW-1:0] OP_STR    = 6'd23;
  localparam logic [OpW-1:0] OP_STRB   = 6'd24;
  localparam logic [OpW-1:0] OP_LDRH   = 6'd25;
  localparam logic [OpW-1:0] OP_LDRSB  = 6'd26;
  localparam logic [OpW-1:0] OP_LDRSH  = 6'd27;
  localparam logic [OpW-1:0] OP_STRH   = 6'd28;
  localparam logic [OpW-1:0] OP_LDRD   = 6'd29;
  localparam logic [OpW-1:0] OP_STRD   = 6'd30;
  localparam logic [OpW-1:0] OP_LDM    = 6'd31;
  localparam logic [OpW-1:0] OP_STM    = 6'd32;
  localparam logic [OpW-1:0] OP_SWP    = 6'd33;
  localparam logic [OpW-1:0] OP_SWPB   = 6'd34;
  localparam logic [OpW-1:0] OP_MRS    = 6'd35;
  localparam logic [OpW-1:0] OP_MSR    = 6'd36;
  localparam logic [OpW-1:0] OP_MUL    = 6'd37;
  localparam logic [OpW-1:0] OP_MLA    = 6'd38;
  localparam logic [OpW-1:0] OP_UMULL  = 6'd39;
  localparam logic [OpW-1:0] OP_UMLAL  = 6'd40;
  localparam logic [OpW-1:0] OP_SMULL  = 6'd41;
  localparam logic [OpW-1:0] OP_SMLAL  = 6'd42;
  localparam logic [OpW-1:0] OP_SMLAXY = 6'd43;
  localparam logic [OpW-1:0] OP_SMLAWY = 6'd44;
  localparam logic [OpW-1:0] OP_SMULWY = 6'd45;
  localparam logic [OpW-1:0] OP_SMLALXY = 6'd46;
  localparam logic [OpW-1:0] OP_SMULXY = 6'd47;
  localparam logic [OpW-1:0] OP_QADD   = 6'd48;
  localparam logic [OpW-1:0] OP_QSUB   = 6'd49;
  localparam logic [OpW-1:0] OP_QDADD  = 6'd50;
  localparam logic [OpW-1:0] OP_QDSUB  = 6'd51;
  localparam logic [OpW-1:0] OP_CLZ    = 6'd52;
  localparam logic [OpW-1:0] OP_SWI    = 6'd53;
  localparam logic [OpW-1:0] OP_PLD    = 6'd54;
  localparam logic [OpW-1:0] OP_MCR    = 6'd55;
  localparam logic [OpW-1:0] OP_MRC    = 6'd56;
  localparam logic [OpW-1:0] OP_CDP    = 6'd57;
  localparam logic [OpW-1:0] OP_UNDEF  = 6'd58;

  localparam logic [3:0] COND_AL    = 4'd14;
  localparam logic [3:0] COND_NV    = 4'd15;
  localparam logic [3:0] REG_PC     = 4'd15;
  localparam logic [3:0] REG_LR     = 4'd14;

  // modifier flag masks
  localparam logic [MfW-1:0] MF_SETFLAGS = 14'h0001;
  localparam logic [MfW-1:0] MF_REGFORM  = 14'h0002;
  localparam logic [MfW-1:0] MF_SHREG    = 14'h0004;
  localparam logic [MfW-1:0] MF_PRE      = 14'h0008;
  localparam logic [MfW-1:0] MF_ADD      = 14'h0010;
  localparam logic [MfW-1:0] MF_WB       = 14'h0020;
  localparam logic [MfW-1:0] MF_BYTE     = 14'h0040;
  localparam logic [MfW-1:0] MF_SBIT     = 14'h0080;
  localparam logic [MfW-1:0] MF_LOAD     = 14'h0100;
  localparam logic [MfW-1:0] MF_SPSR     = 14'h0200;
  localparam logic [MfW-1:0] MF_XTOP     = 14'h0400;
  localparam logic [MfW-1:0] MF_YTOP     = 14'h0800;
  localparam logic [MfW-1:0] MF_LINK     = 14'h1000;
  localparam logic [MfW-1:0] MF_EXCH     = 14'h2000;

  // flow flag masks
  localparam logic [FfW-1:0] FF_BRANCH   = 6'h01;
  localparam logic [FfW-1:0] FF_CALL     = 6'h02;
  localparam logic [FfW-1:0] FF_INDIRECT = 6'h04;
  localparam logic [FfW-1:0] FF_RETURN   = 6'h08;
  localparam logic [FfW-1:0] FF_PCWRITE  = 6'h10;
  localparam logic [FfW-1:0] FF_UNDEF    = 6'h20;

  localparam logic [StyW-1:0] SHIFT_ROR = 3'd3;
  localparam logic [StyW-1:0] SHIFT_RRX = 3'd4;

  localparam logic [CcW-1:0] CC_KEEP = 2'd2;

  // fixed encodings of the branch-exchange and count-leading-zeros forms
  localparam logic [31:0] BX_MASK   = 32'h0FFFFFF0;
  localparam logic [31:0] BX_PAT    = 32'h012FFF10;
  localparam logic [31:0] BLXR_PAT  = 32'h012FFF30;
  localparam logic [31:0] CLZ_MASK  = 32'h0FFF0FF0;
  localparam logic [31:0] CLZ_PAT   = 32'h016F0F10;

  localparam logic [31:0] PC_AHEAD  = 32'd8;
  localparam logic [31:0] HALF_STEP = 32'd2;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [3:0]       cond;
    logic [RegW-1:0]  rd;
    logic [RegW-1:0]  rn;
    logic [RegW-1:0]  rm;
    logic [RegW-1:0]  rs;
    logic [ImmW-1:0]  imm;
    logic [StyW-1:0]  sty;
    logic [SamtW-1:0] samt;
    logic [MfW-1:0]   mf;
    logic [FfW-1:0]   ff;
    logic [CcW-1:0]   cc;
  } dec_rec_t;

endpackage
`default_nettype wire

[hdl/aid_decode.sv]
// combinational decode of one instruction word into a decoded record
`default_nettype none
module aid_decode (
  input  wire logic [aid_pkg::InstrW-1:0] instr,
  input  wire logic [aid_pkg::AddrW-1:0]  pc,
  output aid_pkg::dec_rec_t               rec
);

  logic [31:0] br_off;
  logic [31:0] br_tgt;
  logic [2:0]  top3;
  logic [3:0]  top4;
  logic [4:0]  hi5;
  logic [3:0]  low;
  logic [3:0]  opc;
  logic        s;

  function automatic aid_pkg::dec_rec_t shifted_reg(aid_pkg::dec_rec_t d_in,
                                                    logic [31:0] w, logic allow);
    aid_pkg::dec_rec_t d;
    d = d_in;
    d.mf = d.mf | aid_pkg::MF_REGFORM;
    d.rm = w[3:0];
    d.sty = {1'b0, w[6:5]};
    if (allow && w[4]) begin
      d.mf = d.mf | aid_pkg::MF_SHREG;
      d.rs = w[11:8];
    end else begin
      d.samt = w[11:7];
      if (d.sty == aid_pkg::SHIFT_ROR && w[11:7] == 5'd0) begin
        d.sty = aid_pkg::SHIFT_RRX;
      end
    end
    return d;
  endfunction

  function automatic aid_pkg::dec_rec_t operand2(aid_pkg::dec_rec_t d_in, logic [31:0] w);
    aid_pkg::dec_rec_t d;
    logic [31:0] v;
    logic [63:0] dbl;
    logic [4:0]  r;
    d = d_in;
    v = {24'd0, w[7:0]};
    dbl = {v, v} >> {w[11:8], 1'b0};
    r = {w[11:8], 1'b0};
    if (w[25]) begin
      if (r == 5'd0) begin
        d.imm = v;
        d.cc = aid_pkg::CC_KEEP;
      end else begin
        d.imm = dbl[31:0];
        d.cc = {1'b0, dbl[31]};
      end
    end else begin
      d = shifted_reg(d, w, 1'b1);
    end
    return d;
  endfunction

  function automatic aid_pkg::dec_rec_t mem_addr_bits(aid_pkg::dec_rec_t d_in,
                                                      logic [31:0] w);
    aid_pkg::dec_rec_t d;
    d = d_in;
    d.rn = w[19:16];
    d.rd = w[15:12];
    if (w[24]) d.mf = d.mf | aid_pkg::MF_PRE;
    if (w[23]) d.mf = d.mf | aid_pkg::MF_ADD;
    // post-indexed transfers always write the base back
    if (w[21] || !w[24]) d.mf = d.mf | aid_pkg::MF_WB;
    return d;
  endfunction

  assign br_off = {{6{instr[23]}}, instr[23:0], 2'b00};
  assign br_tgt = pc + aid_pkg::PC_AHEAD + br_off;
  assign top3   = instr[27:25];
  assign top4   = instr[27:24];
  assign hi5    = instr[27:23];
  assign low    = instr[7:4];
  assign opc    = instr[24:21];
  assign s      = instr[20];

  always_comb begin
    rec = '0;
    rec.cond = instr[31:28];
    if (rec.cond == aid_pkg::COND_NV && top3 == 3'b101) begin
      rec.op = aid_pkg::OP_BLXI;
      rec.cond = aid_pkg::COND_AL;
      rec.imm = br_tgt + (instr[24] ? aid_pkg::HALF_STEP : 32'd0);
      rec.mf = aid_pkg::MF_LINK | aid_pkg::MF_EXCH;
      rec.ff = aid_pkg::FF_BRANCH | aid_pkg::FF_CALL | aid_pkg::FF_PCWRITE;
    end else if (rec.cond == aid_pkg::COND_NV && instr[27:26] == 2'b01 && instr[24] &&
                 instr[22] && !instr[21] && instr[20] && instr[15:12] == aid_pkg::REG_PC) begin
      rec.op = aid_pkg::OP_PLD;
      rec.cond = aid_pkg::COND_AL;
    end else if ((instr & aid_pkg::BX_MASK) == aid_pkg::BX_PAT) begin
      rec.op = aid_pkg::OP_BX;
      rec.rm = instr[3:0];
      rec.mf = aid_pkg::MF_EXCH;
      rec.ff = aid_pkg::FF_BRANCH | aid_pkg::FF_INDIRECT |
               ((instr[3:0] == aid_pkg::REG_LR) ? aid_pkg::FF_RETURN : '0);
    end else if ((instr & aid_pkg::BX_MASK) == aid_pkg::BLXR_PAT) begin
      rec.op = aid_pkg::OP_BLXR;
      rec.rm = instr[3:0];
      rec.mf = aid_pkg::MF_LINK | aid_pkg::MF_EXCH;
      rec.ff = aid_pkg::FF_BRANCH | aid_pkg::FF_CALL | aid_pkg::FF_INDIRECT |
               aid_pkg::FF_PCWRITE;
    end else if ((instr & aid_pkg::CLZ_MASK) == aid_pkg::CLZ_PAT) begin
      rec.op = aid_pkg::OP_CLZ;
      rec.rd = instr[15:12];
      rec.rm = instr[3:0];
    end else if (top3 == 3'b101) begin
      rec.op = instr[24] ? aid_pkg::OP_BL : aid_pkg::OP_B;
      rec.imm = br_tgt;
      rec.mf = instr[24] ? aid_pkg::MF_LINK : '0;
      rec.ff = aid_pkg::FF_BRANCH | (instr[24] ? aid_pkg::FF_CALL : '0);
    end else if (top4 == 4'b1111) begin
      rec.op = aid_pkg::OP_SWI;
      rec.imm = {8'd0, instr[23:0]};
    end else if (top4 == 4'b1110) begin
      rec.rs = instr[11:8];
      rec.rn = instr[19:16];
      rec.rm = instr[3:0];
      rec.rd = instr[15:12];
      if (instr[4]) begin
        rec.op = instr[20] ? aid_pkg::OP_MRC : aid_pkg::OP_MCR;
        rec.mf = instr[20] ? aid_pkg::MF_LOAD : '0;
        rec.imm = {25'd0, instr[7:5], 1'b0, instr[23:21]};
      end else begin
        rec.op = aid_pkg::OP_CDP;
        rec.imm = {25'd0, instr[7:5], instr[23:20]};
      end
    end else if (top3 == 3'b100) begin
      rec.op = instr[20] ? aid_pkg::OP_LDM : aid_pkg::OP_STM;
      rec.rn = instr[19:16];
      rec.imm = {16'd0, instr[15:0]};
      if (instr[24]) rec.mf = rec.mf | aid_pkg::MF_PRE;
      if (instr[23]) rec.mf = rec.mf | aid_pkg::MF_ADD;
      if (instr[22]) rec.mf = rec.mf | aid_pkg::MF_SBIT;
      if (instr[21]) rec.mf = rec.mf | aid_pkg::MF_WB;
      if (instr[20]) begin
        rec.mf = rec.mf | aid_pkg::MF_LOAD;
        // empty list or pc in list loads the pc
        if (instr[15] || instr[15:0] == 16'd0) begin
          rec.ff = aid_pkg::FF_PCWRITE | aid_pkg::FF_BRANCH | aid_pkg::FF_INDIRECT |
                   aid_pkg::FF_RETURN;
        end
      end
    end else if (instr[27:26] == 2'b01) begin
      if (instr[25] && instr[4]) begin
        rec.op = aid_pkg::OP_UNDEF;
        rec.ff = aid_pkg::FF_UNDEF;
      end else begin
        if (instr[20]) rec.op = instr[22] ? aid_pkg::OP_LDRB : aid_pkg::OP_LDR;
        else rec.op = instr[22] ? aid_pkg::OP_STRB : aid_pkg::OP_STR;
        rec = mem_addr_bits(rec, instr);
        if (instr[22]) rec.mf = rec.mf | aid_pkg::MF_BYTE;
        if (instr[25]) rec = shifted_reg(rec, instr, 1'b0);
        else rec.imm = {20'd0, instr[11:0]};
        if (instr[20] && instr[15:12] == aid_pkg::REG_PC) begin
          rec.ff = aid_pkg::FF_PCWRITE | aid_pkg::FF_BRANCH | aid_pkg::FF_INDIRECT;
        end
      end
    end else if (instr[27:26] == 2'b00) begin
      if (!instr[25] && low == 4'b1001 && hi5 == 5'b00000) begin
        rec.op = instr[21] ? aid_pkg::OP_MLA : aid_pkg::OP_MUL;
        rec.mf = s ? aid_pkg::MF_SETFLAGS : '0;
        rec.rd = instr[19:16];
        rec.rn = instr[15:12];
        rec.rs = instr[11:8];
        rec.rm = instr[3:0];
      end else if (!instr[25] && low == 4'b1001 && hi5 == 5'b00001) begin
        case (instr[22:21])
          2'b00:   rec.op = aid_pkg::OP_UMULL;
          2'b01:   rec.op = aid_pkg::OP_UMLAL;
          2'b10:   rec.op = aid_pkg::OP_SMULL;
          2'b11:   rec.op = aid_pkg::OP_SMLAL;
          default: rec.op = aid_pkg::OP_UMULL;
        endcase
        rec.mf = s ? aid_pkg::MF_SETFLAGS : '0;
        rec.rd = instr[19:16];
        rec.rn = instr[15:12];
        rec.rs = instr[11:8];
        rec.rm = instr[3:0];
      end else if (!instr[25] && low == 4'b1001 && hi5 == 5'b00010 &&
                   instr[21:20] == 2'b00) begin
        rec.op = instr[22] ? aid_pkg::OP_SWPB : aid_pkg::OP_SWP;
        rec.rn = instr[19:16];
        rec.rd = instr[15:12];
        rec.rm = instr[3:0];
      end else if (!instr[25] && hi5 == 5'b00010 && !s && low == 4'b0101) begin
        case (instr[22:21])
          2'b00:   rec.op = aid_pkg::OP_QADD;
          2'b01:   rec.op = aid_pkg::OP_QSUB;
          2'b10:   rec.op = aid_pkg::OP_QDADD;
          2'b11:   rec.op = aid_pkg::OP_QDSUB;
          default: rec.op = aid_pkg::OP_QADD;
        endcase
        rec.rn = instr[19:16];
        rec.rd = instr[15:12];
        rec.rm = instr[3:0];
      end else if (!instr[25] && hi5 == 5'b00010 && !s && instr[7] && !instr[4]) begin
        rec.rd = instr[19:16];
        rec.rn = instr[15:12];
        rec.rs = instr[11:8];
        rec.rm = instr[3:0];
        if (instr[5]) rec.mf = rec.mf | aid_pkg::MF_XTOP;
        if (instr[6]) rec.mf = rec.mf | aid_pkg::MF_YTOP;
        case (instr[22:21])
          2'b00:   rec.op = aid_pkg::OP_SMLAXY;
          2'b01:   rec.op = instr[5] ? aid_pkg::OP_SMULWY : aid_pkg::OP_SMLAWY;
          2'b10:   rec.op = aid_pkg::OP_SMLALXY;
          2'b11:   rec.op = aid_pkg::OP_SMULXY;
          default: rec.op = aid_pkg::OP_SMLAXY;
        endcase
      end else if (!instr[25] && instr[7] && instr[4]) begin
        if (instr[6:5] == 2'b00) begin
          rec.op = aid_pkg::OP_UNDEF;
          rec.ff = aid_pkg::FF_UNDEF;
        end else begin
          case ({instr[20], instr[6:5]})
            3'b101:  rec.op = aid_pkg::OP_LDRH;
            3'b110:  rec.op = aid_pkg::OP_LDRSB;
            3'b111:  rec.op = aid_pkg::OP_LDRSH;
            3'b001:  rec.op = aid_pkg::OP_STRH;
            3'b010:  rec.op = aid_pkg::OP_LDRD;
            3'b011:  rec.op = aid_pkg::OP_STRD;
            default: rec.op = aid_pkg::OP_UNDEF;
          endcase
          rec = mem_addr_bits(rec, instr);
          if (instr[22]) begin
            rec.imm = {24'd0, instr[11:8], instr[3:0]};
          end else begin
            rec.mf = rec.mf | aid_pkg::MF_REGFORM;
            rec.rm = instr[3:0];
          end
        end
      end else if (!s && opc[3:2] == 2'b10) begin
        // compare opcodes without s are the status register transfers
        if (instr[22]) rec.mf = rec.mf | aid_pkg::MF_SPSR;
        if (!instr[21]) begin
          rec.op = aid_pkg::OP_MRS;
          rec.rd = instr[15:12];
        end else begin
          rec.op = aid_pkg::OP_MSR;
          rec.rd = instr[19:16];
          if (instr[25]) begin
            rec = operand2(rec, instr);
          end else begin
            rec.mf = rec.mf | aid_pkg::MF_REGFORM;
            rec.rm = instr[3:0];
          end
        end
      end else begin
        rec.op = {2'b00, opc};
        if (s) rec.mf = rec.mf | aid_pkg::MF_SETFLAGS;
        rec.rn = instr[19:16];
        rec.rd = instr[15:12];
        rec = operand2(rec, instr);
        if (instr[15:12] == aid_pkg::REG_PC && opc[3:2] != 2'b10) begin
          rec.ff = aid_pkg::FF_PCWRITE | aid_pkg::FF_BRANCH | aid_pkg::FF_INDIRECT;
        end
      end
    end else begin
      rec.op = aid_pkg::OP_UNDEF;
      rec.ff = aid_pkg::FF_UNDEF;
    end
  end

endmodule
`default_nettype wire

[hdl/arm_instruction_decode_core.sv]
// top level of the instruction decoder: input register, decode, result register
`default_nettype none
// Decodes one 32-bit instruction word per transaction into a decoded record
// (operation, condition, register fields, immediate or branch target, shift,
// modifier and flow flags, rotated-immediate carry code). Throughput is one
// transaction per clock: a word is taken every cycle as long as the result
// side keeps up. The word is held in the input register, decoded, and the
// result is presented from the result register, where a result-side stall
// holds it until taken. The decode logic between the two registers is a
// single pass. No state is kept between transactions.
module arm_instruction_decode_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  // instr_word[31:0], fetch_address[63:32]
  input  wire logic [aid_pkg::InDataW-1:0]     in_tdata,
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  // operation[5:0], condition[9:6], reg_dest[13:10], reg_base[17:14],
  // reg_operand[21:18], reg_shift[25:22], immediate[57:26], shift_type[60:58],
  // shift_amount[65:61], modifier_flags[79:66], flow_flags[85:80],
  // imm_carry_code[87:86]
  output      logic [aid_pkg::OutDataW-1:0]    out_tdata
);

  logic                          in_valid_r;
  logic                          in_valid_nxt;
  logic [aid_pkg::InstrW-1:0]    instr_r;
  logic [aid_pkg::AddrW-1:0]     pc_r;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  aid_pkg::dec_rec_t             dec_rec;
  aid_pkg::dec_rec_t             out_rec_r;
  logic                          out_adv;

  aid_decode u_decode (
    .instr (instr_r),
    .pc    (pc_r),
    .rec   (dec_rec)
  );

  // result register can load when empty or being drained
  assign out_adv   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || out_adv;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_tready) in_valid_nxt = in_tvalid;
    if (out_adv) out_valid_nxt = in_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      instr_r <= in_tdata[31:0];
      pc_r    <= in_tdata[63:32];
    end
    if (out_adv && in_valid_r) begin
      out_rec_r <= dec_rec;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rec_r.cc, out_rec_r.ff, out_rec_r.mf, out_rec_r.samt,
                       out_rec_r.sty, out_rec_r.imm, out_rec_r.rs, out_rec_r.rm,
                       out_rec_r.rn, out_rec_r.rd, out_rec_r.cond, out_rec_r.op};

endmodule
`default_nettype wire

[sim/tb_arm_instruction_decode_core.sv]
// self-checking stream testbench for the instruction decoder, with predictor and scoreboard
`timescale 1ns / 1ps
module tb_arm_instruction_decode_core;
  import aid_pkg::*;

  localparam int unsigned RANDOM_WORDS = 800;
  localparam int unsigned NUM_OPS      = OP_UNDEF + 1;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_AT      = 250;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_SHOWN    = 100;
  localparam int unsigned NUM_DIRECTED = 26;

  // corner-case words and the addresses they are fetched from
  localparam logic [31:0] DIR_WORDS [NUM_DIRECTED] = '{
    32'h00000000, 32'hFFFFFFFF, 32'hFBFFFFFE, 32'hF5D0F000, 32'hEA7FFFFF, 32'hEB800000,
    32'hE12FFF1E, 32'hE12FFF33, 32'hE16F1F12, 32'hE3A000FF, 32'hE3A004FF, 32'hE3B00CFF,
    32'hE1A00061, 32'hE0910312, 32'hE1A0F00E, 32'hE15FF00F, 32'hE14F0000, 32'hE12CF001,
    32'hE368F4FF, 32'hE59FF004, 32'hE4801004, 32'hE7900011, 32'hE1B00091, 32'hE8900000,
    32'hE8BD8000, 32'hED900000
  };
  localparam logic [31:0] DIR_PCS [NUM_DIRECTED] = '{
    32'h00000000, 32'hFFFFFFFF, 32'h00000000, 32'h00001000, 32'hFFFFFFF0, 32'h00000000,
    32'h80000000, 32'h7FFFFFFC, 32'h00000100, 32'h00000104, 32'h00000108, 32'h0000010C,
    32'h00000110, 32'h00000114, 32'h00000118, 32'h0000011C, 32'h00000120, 32'h00000124,
    32'h00000128, 32'h0000012C, 32'h00000130, 32'h00000134, 32'h00000138, 32'h0000013C,
    32'h00000140, 32'h00000144
  };

  class decode_scoreboard;
    dec_rec_t    expected_q[$];
    logic [31:0] word_q[$];
    int unsigned mismatches;
    int unsigned compared;
    int unsigned shown;
    bit [63:0]   ops_seen;

    function logic [31:0] jump_dest(logic [31:0] w, logic [31:0] pc);
      return pc + PC_AHEAD + {{6{w[23]}}, w[23:0], 2'b00};
    endfunction

    function dec_rec_t undef_rec(logic [3:0] cond);
      dec_rec_t d;
      d = '0;
      d.cond = cond;
      d.op = OP_UNDEF;
      d.ff = FF_UNDEF;
      return d;
    endfunction

    function void shifted_operand(inout dec_rec_t d, input logic [31:0] w, input bit allow_rs);
      d.mf |= MF_REGFORM;
      d.rm = w[3:0];
      d.sty = {1'b0, w[6:5]};
      if (allow_rs && w[4]) begin
        d.mf |= MF_SHREG;
        d.rs = w[11:8];
      end else begin
        d.samt = w[11:7];
        if (d.sty == SHIFT_ROR && d.samt == 5'd0) d.sty = SHIFT_RRX;
      end
    endfunction

    function void data_operand(inout dec_rec_t d, input logic [31:0] w);
      logic [63:0] twice;
      int unsigned rot;
      if (w[25]) begin
        rot = 2 * w[11:8];
        if (rot == 0) begin
          d.imm = {24'b0, w[7:0]};
          d.cc = CC_KEEP;
        end else begin
          // rotate right by reading a window out of the doubled byte
          twice = {24'b0, w[7:0], 24'b0, w[7:0]} >> rot;
          d.imm = twice[31:0];
          d.cc = {1'b0, d.imm[31]};
        end
      end else begin
        shifted_operand(d, w, 1'b1);
      end
    endfunction

    function void transfer_addressing(inout dec_rec_t d, input logic [31:0] w);
      d.rn = w[19:16];
      d.rd = w[15:12];
      if (w[24]) d.mf |= MF_PRE;
      if (w[23]) d.mf |= MF_ADD;
      // post-indexed accesses always update the base
      if (w[21] || !w[24]) d.mf |= MF_WB;
    endfunction

    function void mul_regs(inout dec_rec_t d, input logic [31:0] w);
      d.rd = w[19:16];
      d.rn = w[15:12];
      d.rs = w[11:8];
      d.rm = w[3:0];
    endfunction

    function dec_rec_t decode_instr(logic [31:0] w, logic [31:0] pc);
      dec_rec_t   d;
      logic [3:0] opc;
      logic [1:0] sh;
      d = '0;
      d.cond = w[31:28];
      if (d.cond == COND_NV && w[27:25] == 3'b101) begin
        d.op = OP_BLXI;
        d.cond = COND_AL;
        d.imm = jump_dest(w, pc);
        if (w[24]) d.imm = d.imm + HALF_STEP;
        d.mf = MF_LINK | MF_EXCH;
        d.ff = FF_BRANCH | FF_CALL | FF_PCWRITE;
        return d;
      end
      if (d.cond == COND_NV && w[27:26] == 2'b01 && w[24] && w[22] && !w[21] && w[20] &&
          w[15:12] == REG_PC) begin
        d.op = OP_PLD;
        d.cond = COND_AL;
        return d;
      end
      if ((w & BX_MASK) == BX_PAT) begin
        d.op = OP_BX;
        d.rm = w[3:0];
        d.mf = MF_EXCH;
        d.ff = FF_BRANCH | FF_INDIRECT;
        if (d.rm == REG_LR) d.ff |= FF_RETURN;
        return d;
      end
      if ((w & BX_MASK) == BLXR_PAT) begin
        d.op = OP_BLXR;
        d.rm = w[3:0];
        d.mf = MF_LINK | MF_EXCH;
        d.ff = FF_BRANCH | FF_CALL | FF_INDIRECT | FF_PCWRITE;
        return d;
      end
      if ((w & CLZ_MASK) == CLZ_PAT) begin
        d.op = OP_CLZ;
        d.rd = w[15:12];
        d.rm = w[3:0];
        return d;
      end
      if (w[27:25] == 3'b101) begin
        d.imm = jump_dest(w, pc);
        d.ff = FF_BRANCH;
        if (w[24]) begin
          d.op = OP_BL;
          d.mf = MF_LINK;
          d.ff |= FF_CALL;
        end else begin
          d.op = OP_B;
        end
        return d;
      end
      if (w[27:24] == 4'hF) begin
        d.op = OP_SWI;
        d.imm = {8'b0, w[23:0]};
        return d;
      end
      if (w[27:24] == 4'hE) begin
        d.rs = w[11:8];
        d.rn = w[19:16];
        d.rm = w[3:0];
        d.rd = w[15:12];
        if (w[4]) begin
          d.op = w[20] ? OP_MRC : OP_MCR;
          if (w[20]) d.mf = MF_LOAD;
          d.imm = {25'b0, w[7:5], 1'b0, w[23:21]};
        end else begin
          d.op = OP_CDP;
          d.imm = {25'b0, w[7:5], w[23:20]};
        end
        return d;
      end
      if (w[27:25] == 3'b100) begin
        d.op = w[20] ? OP_LDM : OP_STM;
        d.rn = w[19:16];
        d.imm = {16'b0, w[15:0]};
        if (w[24]) d.mf |= MF_PRE;
        if (w[23]) d.mf |= MF_ADD;
        if (w[22]) d.mf |= MF_SBIT;
        if (w[21]) d.mf |= MF_WB;
        if (w[20]) begin
          d.mf |= MF_LOAD;
          if (w[15] || w[15:0] == 16'd0)
            d.ff = FF_PCWRITE | FF_BRANCH | FF_INDIRECT | FF_RETURN;
        end
        return d;
      end
      if (w[27:26] == 2'b01) begin
        if (w[25] && w[4]) return undef_rec(d.cond);
        case ({w[20], w[22]})
          2'b10:   d.op = OP_LDR;
          2'b11:   d.op = OP_LDRB;
          2'b00:   d.op = OP_STR;
          default: d.op = OP_STRB;
        endcase
        transfer_addressing(d, w);
        if (w[22]) d.mf |= MF_BYTE;
        if (w[25]) shifted_operand(d, w, 1'b0);
        else d.imm = {20'b0, w[11:0]};
        if (w[20] && d.rd == REG_PC) d.ff = FF_PCWRITE | FF_BRANCH | FF_INDIRECT;
        return d;
      end
      if (w[27:26] == 2'b00) begin
        opc = w[24:21];
        if (!w[25]) begin
          if (w[7:4] == 4'b1001) begin
            if (w[27:23] == 5'b00000) begin
              d.op = w[21] ? OP_MLA : OP_MUL;
              if (w[20]) d.mf = MF_SETFLAGS;
              mul_regs(d, w);
              return d;
            end
            if (w[27:23] == 5'b00001) begin
              d.op = OP_UMULL + 6'({w[22], w[21]});
              if (w[20]) d.mf = MF_SETFLAGS;
              mul_regs(d, w);
              return d;
            end
            if (w[27:23] == 5'b00010 && w[21:20] == 2'b00) begin
              d.op = w[22] ? OP_SWPB : OP_SWP;
              d.rn = w[19:16];
              d.rd = w[15:12];
              d.rm = w[3:0];
              return d;
            end
          end
          if (w[27:23] == 5'b00010 && !w[20]) begin
            if (w[7:4] == 4'b0101) begin
              d.op = OP_QADD + 6'(w[22:21]);
              d.rn = w[19:16];
              d.rd = w[15:12];
              d.rm = w[3:0];
              return d;
            end
            if (w[7] && !w[4]) begin
              mul_regs(d, w);
              if (w[5]) d.mf |= MF_XTOP;
              if (w[6]) d.mf |= MF_YTOP;
              case (w[22:21])
                2'd0:    d.op = OP_SMLAXY;
                2'd1:    d.op = w[5] ? OP_SMULWY : OP_SMLAWY;
                2'd2:    d.op = OP_SMLALXY;
                default: d.op = OP_SMULXY;
              endcase
              return d;
            end
          end
          if (w[7] && w[4]) begin
            sh = w[6:5];
            if (sh == 2'd0) return undef_rec(d.cond);
            case ({w[20], sh})
              3'b101:  d.op = OP_LDRH;
              3'b110:  d.op = OP_LDRSB;
              3'b111:  d.op = OP_LDRSH;
              3'b001:  d.op = OP_STRH;
              3'b010:  d.op = OP_LDRD;
              default: d.op = OP_STRD;
            endcase
            transfer_addressing(d, w);
            if (w[22]) begin
              d.imm = {24'b0, w[11:8], w[3:0]};
            end else begin
              d.mf |= MF_REGFORM;
              d.rm = w[3:0];
            end
            return d;
          end
        end
        // compare opcodes without S are the status register transfers
        if (!w[20] && opc[3:2] == 2'b10) begin
          if (w[22]) d.mf |= MF_SPSR;
          if (!w[21]) begin
            d.op = OP_MRS;
            d.rd = w[15:12];
            return d;
          end
          d.op = OP_MSR;
          d.rd = w[19:16];
          if (w[25]) begin
            data_operand(d, w);
          end else begin
            d.mf |= MF_REGFORM;
            d.rm = w[3:0];
          end
          return d;
        end
        d.op = {2'b00, opc};
        if (w[20]) d.mf |= MF_SETFLAGS;
        d.rn = w[19:16];
        d.rd = w[15:12];
        data_operand(d, w);
        if (d.rd == REG_PC && opc[3:2] != 2'b10) d.ff = FF_PCWRITE | FF_BRANCH | FF_INDIRECT;
        return d;
      end
      return undef_rec(d.cond);
    endfunction

    function void note_word(logic [31:0] w, logic [31:0] pc);
      expected_q.push_back(decode_instr(w, pc));
      word_q.push_back(w);
    endfunction

    function void field_diff(string name, logic [31:0] w, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        mismatches++;
        // keep the log short when the block is badly broken
        if (shown < MAX_SHOWN)
          $display("%0t: word %h %s expected %h actual %h", $time, w, name, e, a);
        shown++;
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] t);
      dec_rec_t    e;
      dec_rec_t    a;
      logic [31:0] w;
      a.op   = t[5:0];
      a.cond = t[9:6];
      a.rd   = t[13:10];
      a.rn   = t[17:14];
      a.rm   = t[21:18];
      a.rs   = t[25:22];
      a.imm  = t[57:26];
      a.sty  = t[60:58];
      a.samt = t[65:61];
      a.mf   = t[79:66];
      a.ff   = t[85:80];
      a.cc   = t[87:86];
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with no decode pending, expected none actual %h", $time, t);
        return;
      end
      e = expected_q.pop_front();
      w = word_q.pop_front();
      compared++;
      ops_seen[e.op] = 1'b1;
      field_diff("operation", w, 32'(e.op), 32'(a.op));
      field_diff("condition", w, 32'(e.cond), 32'(a.cond));
      field_diff("reg_dest", w, 32'(e.rd), 32'(a.rd));
      field_diff("reg_base", w, 32'(e.rn), 32'(a.rn));
      field_diff("reg_operand", w, 32'(e.rm), 32'(a.rm));
      field_diff("reg_shift", w, 32'(e.rs), 32'(a.rs));
      field_diff("immediate", w, e.imm, a.imm);
      field_diff("shift_type", w, 32'(e.sty), 32'(a.sty));
      field_diff("shift_amount", w, 32'(e.samt), 32'(a.samt));
      field_diff("modifier_flags", w, 32'(e.mf), 32'(a.mf));
      field_diff("flow_flags", w, 32'(e.ff), 32'(a.ff));
      field_diff("imm_carry_code", w, 32'(e.cc), 32'(a.cc));
    endfunction
  endclass

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                out_tready = 1'b0;
  wire                 in_tready;
  wire                 out_tvalid;
  wire [OutDataW-1:0]  out_tdata;

  decode_scoreboard sb;
  int unsigned      idle_cycles = 0;
  int unsigned      noise_words = 0;

  arm_instruction_decode_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // every fourth window of 50 transactions runs without idling
  function automatic int unsigned idle_draw(int unsigned idx);
    if ((idx / 50) % 4 == 1) return 0;
    return $urandom_range(0, 11);
  endfunction

  // random word that decodes to the given operation, other bits left random
  function automatic logic [31:0] encode_for(logic [OpW-1:0] op);
    logic [31:0] w;
    w = $urandom;
    if (op < OP_B) begin
      w[27:26] = 2'b00;
      w[24:21] = op[3:0];
      if (op[3:2] == 2'b10) w[20] = 1'b1;
      if (!w[25] && w[4]) w[7] = 1'b0;
      if ($urandom_range(0, 7) == 0) w[15:12] = REG_PC;
      return w;
    end
    case (op)
      OP_B, OP_BL: begin
        w[31:28] = 4'($urandom_range(0, 14));
        w[27:25] = 3'b101;
        w[24] = (op == OP_BL);
      end
      OP_BLXI: begin
        w[31:28] = COND_NV;
        w[27:25] = 3'b101;
      end
      OP_BX:   w = (w & ~BX_MASK) | BX_PAT;
      OP_BLXR: w = (w & ~BX_MASK) | BLXR_PAT;
      OP_CLZ:  w = (w & ~CLZ_MASK) | CLZ_PAT;
      OP_LDR, OP_LDRB, OP_STR, OP_STRB: begin
        w[27:26] = 2'b01;
        w[22] = (op == OP_LDRB || op == OP_STRB);
        w[20] = (op == OP_LDR || op == OP_LDRB);
        if (w[25]) w[4] = 1'b0;
        if ($urandom_range(0, 7) == 0) w[15:12] = REG_PC;
      end
      OP_LDRH, OP_LDRSB, OP_LDRSH, OP_STRH, OP_LDRD, OP_STRD: begin
        w[27:25] = 3'b000;
        w[7] = 1'b1;
        w[4] = 1'b1;
        w[20] = (op == OP_LDRH || op == OP_LDRSB || op == OP_LDRSH);
        if (op == OP_LDRH || op == OP_STRH) w[6:5] = 2'd1;
        else if (op == OP_LDRSB || op == OP_LDRD) w[6:5] = 2'd2;
        else w[6:5] = 2'd3;
      end
      OP_LDM, OP_STM: begin
        w[27:25] = 3'b100;
        w[20] = (op == OP_LDM);
        case ($urandom_range(0, 5))
          0: w[15:0] = 16'd0;
          1: w[15] = 1'b1;
          default: ;
        endcase
      end
      OP_SWP, OP_SWPB: begin
        w[27:23] = 5'b00010;
        w[22] = (op == OP_SWPB);
        w[21:20] = 2'b00;
        w[7:4] = 4'b1001;
      end
      OP_MRS, OP_MSR: begin
        w[27:26] = 2'b00;
        w[24:23] = 2'b10;
        w[21] = (op == OP_MSR);
        w[20] = 1'b0;
        if (!w[25]) begin
          // keep clear of the multiply, saturating and exchange encodings
          w[7] = 1'b0;
          if (w[7:4] == 4'b0101) w[4] = 1'b0;
          if (w[7:4] == 4'b0001 || w[7:4] == 4'b0011) w[8] = 1'b0;
        end
      end
      OP_MUL, OP_MLA: begin
        w[27:22] = 6'b000000;
        w[21] = (op == OP_MLA);
        w[7:4] = 4'b1001;
      end
      OP_UMULL, OP_UMLAL, OP_SMULL, OP_SMLAL: begin
        w[27:23] = 5'b00001;
        w[22] = (op == OP_SMULL || op == OP_SMLAL);
        w[21] = (op == OP_UMLAL || op == OP_SMLAL);
        w[7:4] = 4'b1001;
      end
      OP_SMLAXY, OP_SMLAWY, OP_SMULWY, OP_SMLALXY, OP_SMULXY: begin
        w[27:23] = 5'b00010;
        w[20] = 1'b0;
        w[7] = 1'b1;
        w[4] = 1'b0;
        case (op)
          OP_SMLAXY:  w[22:21] = 2'd0;
          OP_SMLAWY:  begin w[22:21] = 2'd1; w[5] = 1'b0; end
          OP_SMULWY:  begin w[22:21] = 2'd1; w[5] = 1'b1; end
          OP_SMLALXY: w[22:21] = 2'd2;
          default:    w[22:21] = 2'd3;
        endcase
      end
      OP_QADD, OP_QSUB, OP_QDADD, OP_QDSUB: begin
        w[27:23] = 5'b00010;
        w[22:21] = 2'(op - OP_QADD);
        w[20] = 1'b0;
        w[7:4] = 4'b0101;
      end
      OP_SWI: w[27:24] = 4'hF;
      OP_PLD: begin
        w[31:28] = COND_NV;
        w[27:26] = 2'b01;
        w[24] = 1'b1;
        w[22] = 1'b1;
        w[21] = 1'b0;
        w[20] = 1'b1;
        w[15:12] = REG_PC;
      end
      OP_MCR, OP_MRC: begin
        w[27:24] = 4'hE;
        w[20] = (op == OP_MRC);
        w[4] = 1'b1;
      end
      OP_CDP: begin
        w[27:24] = 4'hE;
        w[4] = 1'b0;
      end
      default: begin
        case ($urandom_range(0, 2))
          0: begin
            // register offset with bit 4 set
            w[27:25] = 3'b011;
            w[4] = 1'b1;
          end
          1: begin
            // multiply-shaped word outside the multiply and swap groups
            w[27:23] = 5'b00011;
            w[7:4] = 4'b1001;
          end
          default: w[27:25] = 3'b110;
        endcase
      end
    endcase
    return w;
  endfunction

  task automatic send_word(logic [31:0] w, logic [31:0] pc, int unsigned gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {pc, w};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_word(in_tdata[31:0], in_tdata[63:32]);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d decodes pending", $time,
                 idle_cycles, sb.expected_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off so the decoder backs up
  initial begin : result_sink
    int unsigned taken;
    int unsigned hold;
    bit          held;
    taken = 0;
    held = 1'b0;
    forever begin
      if (!held && taken >= HOLD_AT) begin
        hold = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        hold = idle_draw(taken + 25);
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  initial begin : stimulus
    logic [31:0]    w;
    logic [OpW-1:0] op;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_word(DIR_WORDS[i], DIR_PCS[i], idle_draw(i));
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      // first pass walks every operation once, then random picks
      if (i < NUM_OPS) op = OpW'(i);
      else op = OpW'($urandom_range(0, OP_UNDEF));
      if (i >= NUM_OPS && $urandom_range(0, 7) == 0) begin
        w = $urandom;
        noise_words++;
      end else begin
        w = encode_for(op);
      end
      send_word(w, $urandom, idle_draw(i + NUM_DIRECTED));
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("decoded %0d instruction words: %0d corner cases, %0d targeted, %0d unstructured",
             sb.compared, NUM_DIRECTED, RANDOM_WORDS - noise_words, noise_words);
    $display("%0d of %0d operation codes reached, %0d field mismatches, one long output stall",
             $countones(sb.ops_seen), NUM_OPS, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
